// ----- rtl/afdc_pkg.sv -----
// Shared types, codes and constants of the audio frame deframer and checker.
`default_nettype none
package afdc_pkg;

    localparam int HDR_BYTES   = 30;
    localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
    localparam int COUNT_W     = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int AFDC_QUEUE_DEPTH = 4;
    localparam int AFDC_RES_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DN_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_SAMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DN_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DN_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY  = 3'd7;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_INCOMPLETE = 4'd1;
    localparam logic [3:0] ST_VERSION    = 4'd2;
    localparam logic [3:0] ST_DIRECTION  = 4'd3;
    localparam logic [3:0] ST_MISMATCH   = 4'd4;
    localparam logic [3:0] ST_FLAGS      = 4'd5;
    localparam logic [3:0] ST_EPOCH      = 4'd6;
    localparam logic [3:0] ST_START      = 4'd7;
    localparam logic [3:0] ST_SAMPLES    = 4'd8;
    localparam logic [3:0] ST_PAYLOAD    = 4'd9;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [3:0]  status;
        logic [7:0]  direction;
        logic [15:0] flags;
        logic [31:0] epoch;
        logic [31:0] sequence_number;
        logic [63:0] first_sample;
        logic [31:0] sample_count;
        logic [31:0] generation;
        logic [15:0] payload_length;
        logic        frame_good;
    } t_out;

    typedef struct packed {
        logic               is_payload;
        logic               is_end;
        logic [7:0]         data_byte;
        logic [COUNT_W-1:0] count;
        t_hdr               hdr;
    } t_req;

endpackage
`default_nettype wire

// ----- rtl/audio_frame_deframer_checker_core.sv -----
// Top level of the audio frame deframer and checker.
//
//  Channel   Handshake             Payload       Notes
//  input     push / full           i_data        one frame byte per request
//  result    empty / pop           o_data        payload byte or frame verdict
//  config    i_cfg_we              i_cfg_idx     i_cfg_wdata, no read-back
//
// One byte is taken every cycle while full is low; each result passes both queues.
// A payload byte that ends a frame yields a payload result and then the frame verdict.
// The request queue between front and back end sets how long a stalled result side
// can be absorbed: full rises when it holds QUEUE_DEPTH requests.
// Synchronous active-low reset empties both queues, clears the byte count and
// restores the register defaults.
`default_nettype none
module audio_frame_deframer_checker_core
    import afdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = AFDC_QUEUE_DEPTH,
    parameter int RES_DEPTH   = AFDC_RES_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire t_in                   i_data,
    output logic                       empty,
    input  wire logic                  pop,
    output t_out                       o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);
    logic q_wr, q_full, q_rd, q_empty, acc;
    logic res_wr, res_full;
    t_req req_in, req_out;
    t_out res_in;

    assign acc  = push && !q_full;
    assign full = q_full;

    afdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_in     (i_data),
        .o_req_wr (q_wr),
        .o_req    (req_in)
    );

    afdc_queue #(
        .WIDTH ($bits(t_req)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (req_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (req_out),
        .o_empty (q_empty)
    );

    afdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_req       (req_out),
        .o_q_rd      (q_rd),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (res_in)
    );

    afdc_queue #(
        .WIDTH ($bits(t_out)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (o_data),
        .o_empty (empty)
    );

    a_req_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_empty)
        else $error("request taken from an empty queue");

    a_res_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !res_full && !q_empty)
        else $error("result written without room or without a request");

    a_good_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.kind == KIND_VERDICT) |->
            (o_data.frame_good == (o_data.status == ST_OK)))
        else $error("verdict good flag disagrees with status");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_wr && res_in.kind == KIND_PAYLOAD) |=> !empty)
        else $error("payload result lost after write");
endmodule
`default_nettype wire

// ----- rtl/afdc_queue.sv -----
// Small first-in first-out queue of packed words.
`default_nettype none
module afdc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({wr_ok, rd_ok})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/afdc_front.sv -----
// Front end: counts frame bytes, stores the header and issues requests to the back end.
`default_nettype none
module afdc_front
    import afdc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_acc,
    input  wire t_in  i_in,
    output logic      o_req_wr,
    output t_req      o_req
);
    logic [COUNT_W-1:0] r_count, n_count, cnt_inc;
    logic [7:0]         r_hdr [HDR_BYTES];
    logic [HDR_IDX_W-1:0] wr_idx;
    logic               in_hdr;
    t_hdr               hdr_next;

    assign in_hdr  = (r_count < COUNT_W'(HDR_BYTES));
    assign wr_idx  = r_count[HDR_IDX_W-1:0];
    assign cnt_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            hdr_next[k] = (in_hdr && wr_idx == HDR_IDX_W'(k)) ? i_in.data_byte : r_hdr[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_acc) begin
            n_count = i_in.end_of_frame ? '0 : cnt_inc;
        end
    end

    assign o_req_wr         = i_acc && (!in_hdr || i_in.end_of_frame);
    assign o_req.is_payload = !in_hdr;
    assign o_req.is_end     = i_in.end_of_frame;
    assign o_req.data_byte  = i_in.data_byte;
    assign o_req.count      = cnt_inc;
    assign o_req.hdr        = hdr_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && in_hdr) begin
            r_hdr[wr_idx] <= i_in.data_byte;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/afdc_back.sv -----
// Back end: holds the configuration, forms payload results and frame verdicts.
`default_nettype none
module afdc_back
    import afdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_q_empty,
    input  wire t_req                  i_req,
    output logic                       o_q_rd,
    input  wire logic                  i_res_full,
    output logic                       o_res_wr,
    output t_out                       o_res
);
    logic [7:0]  r_version, r_up_code, r_dn_code;
    logic [31:0] r_up_samp, r_dn_low, r_dn_high;
    logic [15:0] r_disc, r_max_pay;
    logic        r_phase, n_phase;

    logic        split, emit_pay;
    logic [7:0]  ver, dir;
    logic [15:0] flg, plen;
    logic [31:0] ep, seq, fs, gen;
    logic [63:0] ss;
    logic [64:0] ss_sum;
    logic        up, down, incomplete;
    logic [3:0]  st;
    t_out        verdict, pay;

    assign split    = i_req.is_payload && i_req.is_end && !r_phase;
    assign emit_pay = i_req.is_payload && !r_phase;
    assign o_res_wr = !i_q_empty && !i_res_full;
    assign o_q_rd   = o_res_wr && !split;

    always_comb begin
        n_phase = r_phase;
        if (o_res_wr) begin
            n_phase = split;
        end
    end

    assign ver    = i_req.hdr[0];
    assign dir    = i_req.hdr[1];
    assign flg    = {i_req.hdr[2], i_req.hdr[3]};
    assign ep     = {i_req.hdr[4], i_req.hdr[5], i_req.hdr[6], i_req.hdr[7]};
    assign seq    = {i_req.hdr[8], i_req.hdr[9], i_req.hdr[10], i_req.hdr[11]};
    assign ss     = {i_req.hdr[12], i_req.hdr[13], i_req.hdr[14], i_req.hdr[15],
                     i_req.hdr[16], i_req.hdr[17], i_req.hdr[18], i_req.hdr[19]};
    assign fs     = {i_req.hdr[20], i_req.hdr[21], i_req.hdr[22], i_req.hdr[23]};
    assign gen    = {i_req.hdr[24], i_req.hdr[25], i_req.hdr[26], i_req.hdr[27]};
    assign plen   = {i_req.hdr[28], i_req.hdr[29]};
    assign ss_sum = {1'b0, ss} + {33'd0, fs};
    assign up     = (dir == r_up_code);
    assign down   = !up && (dir == r_dn_code);
    assign incomplete = (i_req.count < COUNT_W'(HDR_BYTES));

    always_comb begin
        if (incomplete) begin
            st = ST_INCOMPLETE;
        end else if (ver != r_version) begin
            st = ST_VERSION;
        end else if (!up && !down) begin
            st = ST_DIRECTION;
        end else if ({1'b0, plen} != i_req.count - COUNT_W'(HDR_BYTES)) begin
            st = ST_MISMATCH;
        end else if (up ? (flg != '0) : ((flg & ~r_disc) != '0)) begin
            st = ST_FLAGS;
        end else if (ep == '0) begin
            st = ST_EPOCH;
        end else if (ss_sum[64]) begin
            st = ST_START;
        end else if (up ? (fs != r_up_samp) : (fs != r_dn_low && fs != r_dn_high)) begin
            st = ST_SAMPLES;
        end else if (plen == '0 || plen > r_max_pay || (up && gen != '0)) begin
            st = ST_PAYLOAD;
        end else begin
            st = ST_OK;
        end
    end

    always_comb begin
        verdict                 = '0;
        verdict.kind            = KIND_VERDICT;
        verdict.status          = st;
        verdict.frame_good      = (st == ST_OK);
        if (!incomplete) begin
            verdict.direction       = dir;
            verdict.flags           = flg;
            verdict.epoch           = ep;
            verdict.sequence_number = seq;
            verdict.first_sample    = ss;
            verdict.sample_count    = fs;
            verdict.generation      = gen;
            verdict.payload_length  = plen;
        end
        pay              = '0;
        pay.kind         = KIND_PAYLOAD;
        pay.payload_byte = i_req.data_byte;
    end

    assign o_res = emit_pay ? pay : verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_version <= 8'd1;
            r_up_code <= 8'd1;
            r_dn_code <= 8'd2;
            r_up_samp <= 32'd320;
            r_dn_low  <= 32'd320;
            r_dn_high <= 32'd480;
            r_disc    <= 16'd1;
            r_max_pay <= 16'd1024;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VERSION: r_version <= i_cfg_wdata[7:0];
                    CFG_UP_CODE: r_up_code <= i_cfg_wdata[7:0];
                    CFG_DN_CODE: r_dn_code <= i_cfg_wdata[7:0];
                    CFG_UP_SAMP: r_up_samp <= i_cfg_wdata;
                    CFG_DN_LOW:  r_dn_low  <= i_cfg_wdata;
                    CFG_DN_HIGH: r_dn_high <= i_cfg_wdata;
                    CFG_DISC:    r_disc    <= i_cfg_wdata[15:0];
                    CFG_MAX_PAY: r_max_pay <= i_cfg_wdata[15:0];
                    default:     r_max_pay <= r_max_pay;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the audio frame deframer and checker core.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import afdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_BYTES   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER [8] = '{
        CFG_VERSION, CFG_UP_CODE, CFG_DN_CODE, CFG_UP_SAMP,
        CFG_DN_LOW, CFG_DN_HIGH, CFG_DISC, CFG_MAX_PAY
    };

    typedef struct {
        logic [7:0]  version;
        logic [7:0]  up_code;
        logic [7:0]  dn_code;
        logic [31:0] up_samples;
        logic [31:0] dn_low;
        logic [31:0] dn_high;
        logic [15:0] disc_mask;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct {
        logic [7:0]  version;
        logic [7:0]  direction;
        logic [15:0] flags;
        logic [31:0] epoch;
        logic [31:0] seq;
        logic [63:0] start;
        logic [31:0] samples;
        logic [31:0] generation;
        logic [15:0] pay_len;
    } t_frame;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    t_in                   i_data      = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_cfg               cfg;
    t_hdr               hdr_seen;
    logic [COUNT_W-1:0] bytes_seen      = '0;
    t_out               results_due[$];
    t_out               due_result;
    int                 bad_results     = 0;
    int                 bytes_sent      = 0;
    int                 stuck_cycles    = 0;
    int                 send_idle_pct   = 0;
    int                 recv_stall_pct  = 0;
    int                 hold_off_cycles = 0;

    always #6 i_clk = ~i_clk;

    audio_frame_deframer_checker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    function automatic t_cfg reset_cfg();
        return '{version: 8'd1, up_code: 8'd1, dn_code: 8'd2, up_samples: 32'd320,
                 dn_low: 32'd320, dn_high: 32'd480, disc_mask: 16'd1,
                 max_payload: 16'd1024};
    endfunction

    function automatic t_out judge_frame();
        t_out        r;
        logic        up;
        logic        down;
        logic [64:0] end_sample;
        r = '0;
        r.kind = KIND_VERDICT;
        if (bytes_seen < HDR_BYTES) begin
            r.status = ST_INCOMPLETE;
        end else begin
            r.direction       = hdr_seen[1];
            r.flags           = {hdr_seen[2], hdr_seen[3]};
            r.epoch           = {hdr_seen[4], hdr_seen[5], hdr_seen[6], hdr_seen[7]};
            r.sequence_number = {hdr_seen[8], hdr_seen[9], hdr_seen[10], hdr_seen[11]};
            r.first_sample    = {hdr_seen[12], hdr_seen[13], hdr_seen[14], hdr_seen[15],
                                 hdr_seen[16], hdr_seen[17], hdr_seen[18], hdr_seen[19]};
            r.sample_count    = {hdr_seen[20], hdr_seen[21], hdr_seen[22], hdr_seen[23]};
            r.generation      = {hdr_seen[24], hdr_seen[25], hdr_seen[26], hdr_seen[27]};
            r.payload_length  = {hdr_seen[28], hdr_seen[29]};
            up   = (r.direction == cfg.up_code);
            down = !up && (r.direction == cfg.dn_code);
            end_sample = {1'b0, r.first_sample} + {33'b0, r.sample_count};
            if (hdr_seen[0] != cfg.version) begin
                r.status = ST_VERSION;
            end else if (!up && !down) begin
                r.status = ST_DIRECTION;
            end else if (int'(r.payload_length) != int'(bytes_seen) - HDR_BYTES) begin
                r.status = ST_MISMATCH;
            end else if (up ? (r.flags != 16'd0)
                            : ((r.flags & ~cfg.disc_mask) != 16'd0)) begin
                r.status = ST_FLAGS;
            end else if (r.epoch == 32'd0) begin
                r.status = ST_EPOCH;
            end else if (end_sample[64]) begin
                r.status = ST_START;
            end else if (up ? (r.sample_count != cfg.up_samples)
                            : (r.sample_count != cfg.dn_low &&
                               r.sample_count != cfg.dn_high)) begin
                r.status = ST_SAMPLES;
            end else if (r.payload_length == 16'd0 ||
                         r.payload_length > cfg.max_payload) begin
                r.status = ST_PAYLOAD;
            end else if (up && r.generation != 32'd0) begin
                r.status = ST_PAYLOAD;
            end else begin
                r.status = ST_OK;
            end
        end
        r.frame_good = (r.status == ST_OK);
        return r;
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic eof);
        t_out r;
        if (bytes_seen < HDR_BYTES) begin
            hdr_seen[bytes_seen] = b;
        end else begin
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            results_due.push_back(r);
        end
        if (bytes_seen != COUNT_MAX) begin
            bytes_seen++;
        end
        if (eof) begin
            results_due.push_back(judge_frame());
            bytes_seen = '0;
        end
    endfunction

    function automatic string show(t_out r);
        return $sformatf({"kind %0d byte %h status %0d dir %h flags %h epoch %h seq %h ",
                          "start %h samples %h gen %h len %h good %0d"},
                         r.kind, r.payload_byte, r.status, r.direction, r.flags, r.epoch,
                         r.sequence_number, r.first_sample, r.sample_count, r.generation,
                         r.payload_length, r.frame_good);
    endfunction

    function automatic void report_bad(string what, t_out want, t_out got);
        bad_results++;
        if (bad_results <= REPORT_LIMIT) begin
            $display("%s at %0t", what, $realtime);
            $display("  expected: %s", show(want));
            $display("  actual:   %s", show(got));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            pop <= 1'b0;
            hold_off_cycles--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && pop && !empty) begin
            if (results_due.size() == 0) begin
                report_bad("unexpected result", '0, o_data);
            end else begin
                due_result = results_due.pop_front();
                if (o_data !== due_result) begin
                    report_bad("result mismatch", due_result, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= '{data_byte: b, end_of_frame: eof};
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        deframe_byte(b, eof);
        bytes_sent++;
    endtask

    function automatic t_hdr header_bytes(t_frame f);
        t_hdr hb;
        hb[0] = f.version;
        hb[1] = f.direction;
        {hb[2], hb[3]} = f.flags;
        {hb[4], hb[5], hb[6], hb[7]} = f.epoch;
        {hb[8], hb[9], hb[10], hb[11]} = f.seq;
        {hb[12], hb[13], hb[14], hb[15], hb[16], hb[17], hb[18], hb[19]} = f.start;
        {hb[20], hb[21], hb[22], hb[23]} = f.samples;
        {hb[24], hb[25], hb[26], hb[27]} = f.generation;
        {hb[28], hb[29]} = f.pay_len;
        return hb;
    endfunction

    task automatic send_frame(input t_frame f, input int payload_bytes);
        t_hdr hb;
        hb = header_bytes(f);
        for (int k = 0; k < HDR_BYTES; k++) begin
            send_byte(hb[k], payload_bytes == 0 && k == HDR_BYTES - 1);
        end
        for (int k = 0; k < payload_bytes; k++) begin
            send_byte(8'($urandom), k == payload_bytes - 1);
        end
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom), k == n - 1);
        end
    endtask

    task automatic wait_quiet();
        push <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] cfg_word(t_cfg c, logic [CFG_IDX_W-1:0] idx);
        case (idx)
            CFG_VERSION: return {24'($urandom), c.version};
            CFG_UP_CODE: return {24'($urandom), c.up_code};
            CFG_DN_CODE: return {24'($urandom), c.dn_code};
            CFG_UP_SAMP: return c.up_samples;
            CFG_DN_LOW:  return c.dn_low;
            CFG_DN_HIGH: return c.dn_high;
            CFG_DISC:    return {16'($urandom), c.disc_mask};
            default:     return {16'($urandom), c.max_payload};
        endcase
    endfunction

    task automatic load_config(input t_cfg c);
        foreach (CFG_ORDER[k]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_ORDER[k];
            i_cfg_wdata <= cfg_word(c, CFG_ORDER[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg = c;
        @(posedge i_clk);
    endtask

    function automatic t_frame good_frame(logic uplink);
        t_frame f;
        int     lim;
        f.version    = cfg.version;
        f.direction  = uplink ? cfg.up_code : cfg.dn_code;
        f.flags      = uplink ? 16'd0 : (16'($urandom) & cfg.disc_mask);
        f.epoch      = $urandom;
        if (f.epoch == 32'd0) begin
            f.epoch = 32'd1;
        end
        f.seq        = $urandom;
        f.samples    = uplink ? cfg.up_samples
                              : ($urandom_range(1) ? cfg.dn_high : cfg.dn_low);
        f.start      = {$urandom, $urandom} >> $urandom_range(63);
        if (f.start > ~{32'd0, f.samples}) begin
            f.start = ~{32'd0, f.samples};
        end
        f.generation = uplink ? 32'd0 : $urandom;
        lim = (cfg.max_payload < 16'd6) ? int'(cfg.max_payload) : 6;
        if (lim == 0) begin
            lim = 1;
        end
        f.pay_len    = 16'($urandom_range(lim, 1));
        return f;
    endfunction

    function automatic t_frame break_frame(t_frame f);
        case ($urandom_range(7))
            0: f.version ^= 8'($urandom_range(255, 1));
            1: f.direction = 8'($urandom);
            2: f.flags = 16'($urandom);
            3: f.epoch = 32'd0;
            4: begin
                f.start = '1;
                f.samples |= 32'd1;
            end
            5: f.samples = $urandom;
            6: f.pay_len = 16'd0;
            default: f.generation = $urandom | 32'd1;
        endcase
        return f;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.version     = 8'($urandom);
        c.up_code     = 8'($urandom);
        c.dn_code     = ($urandom_range(7) == 0) ? c.up_code : 8'($urandom);
        c.up_samples  = $urandom;
        c.dn_low      = $urandom_range(1) ? $urandom : 32'($urandom_range(1024));
        c.dn_high     = $urandom;
        c.disc_mask   = 16'($urandom);
        c.max_payload = $urandom_range(3) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(16, 1));
        return c;
    endfunction

    task automatic test_default_checks();
        t_frame f;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        f = good_frame(1'b1);
        f.start = ~{32'd0, f.samples};
        f.epoch = '1;
        f.seq = '1;
        send_frame(f, f.pay_len);
        f = good_frame(1'b0);
        f.samples = cfg.dn_high;
        f.flags = cfg.disc_mask;
        f.generation = '1;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        f.version = 8'hFF;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        f.direction = 8'h00;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        send_frame(f, int'(f.pay_len) + 1);
        f = good_frame(1'b0);
        f.flags = 16'hFFFE;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        f.epoch = 32'd0;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        f.start = '1;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        f.samples = 32'd480;
        send_frame(f, f.pay_len);
        f = good_frame(1'b1);
        f.pay_len = 16'd0;
        send_frame(f, 0);
        f = good_frame(1'b1);
        f.generation = '1;
        send_frame(f, f.pay_len);
        send_noise(HDR_BYTES - 1);
        wait_quiet();
    endtask

    task automatic test_config_extremes();
        t_frame f;
        load_config('{version: 8'hFF, up_code: 8'hFF, dn_code: 8'h00, up_samples: '1,
                      dn_low: '0, dn_high: '1, disc_mask: 16'hFFFF,
                      max_payload: 16'hFFFF});
        f = good_frame(1'b0);
        f.flags = 16'hFFFF;
        f.samples = 32'd0;
        f.start = '1;
        send_frame(f, f.pay_len);
        wait_quiet();
        load_config('{version: 8'h00, up_code: 8'h00, dn_code: 8'hFF, up_samples: '0,
                      dn_low: 32'h8000_0000, dn_high: 32'h0000_0001, disc_mask: 16'h0000,
                      max_payload: 16'd1});
        f = good_frame(1'b1);
        f.pay_len = 16'd2;
        send_frame(f, f.pay_len);
        wait_quiet();
    endtask

    task automatic test_shared_codes_no_room();
        t_cfg   c;
        t_frame f;
        c = reset_cfg();
        c.up_code = 8'd7;
        c.dn_code = 8'd7;
        load_config(c);
        f = good_frame(1'b0);
        f.samples = cfg.up_samples;
        f.flags = 16'h0001;
        send_frame(f, f.pay_len);
        wait_quiet();
        c.max_payload = 16'd0;
        load_config(c);
        f = good_frame(1'b1);
        send_frame(f, f.pay_len);
        wait_quiet();
    endtask

    task automatic test_backpressure();
        t_frame f;
        load_config(reset_cfg());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 100;
        f = good_frame(1'b0);
        f.pay_len = 16'd12;
        send_frame(f, f.pay_len);
        wait_quiet();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        t_frame f;
        int     first_byte;
        int     pick;
        load_config(random_cfg());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            pick = $urandom_range(99);
            f = good_frame($urandom_range(1));
            if (pick < 65) begin
                send_frame(f, f.pay_len);
            end else if (pick < 85) begin
                f = break_frame(f);
                send_frame(f, f.pay_len);
            end else if (pick < 92) begin
                send_frame(f, (f.pay_len > 16'd1 && $urandom_range(1)) ?
                              int'(f.pay_len) - 1 : int'(f.pay_len) + 1);
            end else begin
                send_noise($urandom_range(40, 1));
            end
        end
        wait_quiet();
    endtask

    initial begin
        cfg = reset_cfg();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_checks();
        test_config_extremes();
        test_shared_codes_no_room();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(75, 0);
        test_random_traffic(0, 75);
        test_random_traffic(12, 12);
        if (bad_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
